>>> design/level_crossing_controller_unit_macros.svh
// Assertion macros used by the level crossing controller core.
`ifndef LEVEL_CROSSING_CONTROLLER_UNIT_MACROS_SVH
`define LEVEL_CROSSING_CONTROLLER_UNIT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define LCC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define LCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lcc_pkg.sv
// Types and constants of the level crossing controller.
`default_nettype none

package lcc_pkg;

	localparam int unsigned AXLE_COUNT_MAX_DEF = 255;

	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned CFG_INDEX_W = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FLASH_PERIOD    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_AMBER_TICKS     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CLEARANCE_TICKS = 2'd2;

	localparam logic [5:0] FLASH_PERIOD_RST    = 6'd6;
	localparam logic [7:0] AMBER_TICKS_RST     = 8'd40;
	localparam logic [7:0] CLEARANCE_TICKS_RST = 8'd40;

	typedef enum logic [1:0] {
		PH_GREEN    = 2'd0,
		PH_AMBER    = 2'd1,
		PH_RED      = 2'd2,
		PH_REDAMBER = 2'd3
	} phase_t;

	typedef struct packed {
		logic [5:0] flash_period;
		logic [7:0] amber_ticks;
		logic [7:0] clearance_ticks;
	} cfg_t;

	// one control tick, entry_sensor in bit 0
	typedef struct packed {
		logic gong_allowed;
		logic barrier_at_bottom;
		logic barrier_at_top;
		logic exit_sensor;
		logic entry_sensor;
	} item_t;

	// output latch, lamp_red in bit 0
	typedef struct packed {
		logic crossing_closed;
		logic gong_on;
		logic warning_flash;
		logic raise_drive;
		logic lower_drive;
		logic lamp_green;
		logic lamp_amber;
		logic lamp_red;
	} pins_t;

	localparam pins_t PINS_RST = '{lamp_green: 1'b1, default: 1'b0};

endpackage

`default_nettype wire

>>> design/lcc_core.sv
// Axle counting, phase sequencing and output latch of the crossing controller.
`default_nettype none

module lcc_core
	import lcc_pkg::*;
#(
	parameter int unsigned AXLE_COUNT_MAX = AXLE_COUNT_MAX_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         step,
	input  item_t       item,
	input  cfg_t        cfg,
	output pins_t       pins
);

`include "level_crossing_controller_unit_macros.svh"

	localparam int unsigned CW = $clog2(AXLE_COUNT_MAX + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(AXLE_COUNT_MAX);

	logic [CW-1:0] count_q, count_d;
	phase_t        phase_q, phase_d;
	logic [7:0]    amber_q, amber_d;
	logic [7:0]    clear_q, clear_d;
	logic [5:0]    flash_q, flash_d;
	logic          armed_q;
	logic [1:0]    last_q;
	pins_t         pins_q, pins_d;

	logic [1:0] levels, rising;
	logic [CW-1:0] count_in;
	logic       cnt_nz;
	logic       go_red, go_amber, amber_hold;
	logic       clr_done, enter_ra, clr_inc;
	logic [5:0] flash_inc;
	logic       flash_toggle;

	assign levels = {item.exit_sensor, item.entry_sensor};
	assign rising = levels & ~last_q;

	// entry edge first, then exit edge
	always_comb begin
		count_in = count_q;
		if (rising[0] && count_in < CNT_MAX) begin
			count_in = count_in + 1'b1;
		end
		count_d = count_in;
		if (rising[1] && count_in != '0) begin
			count_d = count_in - 1'b1;
		end
	end

	assign cnt_nz = (count_d != '0);

	assign go_red = cnt_nz && (phase_q == PH_RED ||
		(phase_q == PH_AMBER && amber_q >= cfg.amber_ticks));
	assign go_amber   = cnt_nz && !go_red && phase_q != PH_AMBER;
	assign amber_hold = cnt_nz && !go_red && phase_q == PH_AMBER;

	assign clr_done = !cnt_nz && armed_q && phase_q == PH_REDAMBER &&
		clear_q >= cfg.clearance_ticks;
	assign enter_ra = !cnt_nz && armed_q && phase_q == PH_RED;
	assign clr_inc  = !cnt_nz && armed_q && phase_q == PH_REDAMBER && !clr_done;

	assign flash_inc    = flash_q + 1'b1;
	assign flash_toggle = go_red && flash_inc >= cfg.flash_period;

	// next state
	always_comb begin
		phase_d = phase_q;
		amber_d = amber_q;
		clear_d = clear_q;
		flash_d = flash_q;
		if (go_red) begin
			phase_d = PH_RED;
			flash_d = flash_toggle ? 6'd0 : flash_inc;
		end
		if (go_amber) begin
			phase_d = PH_AMBER;
			amber_d = 8'd1;
		end
		if (amber_hold) begin
			amber_d = amber_q + 1'b1;
		end
		if (clr_done) begin
			phase_d = PH_GREEN;
			clear_d = 8'd0;
			amber_d = 8'd0;
		end
		if (enter_ra) begin
			phase_d = PH_REDAMBER;
			clear_d = 8'd1;
		end
		if (clr_inc) begin
			clear_d = clear_q + 1'b1;
		end
	end

	// output latch
	always_comb begin
		pins_d = pins_q;
		if (go_red) begin
			pins_d.lamp_red        = 1'b1;
			pins_d.lamp_amber      = 1'b0;
			pins_d.lamp_green      = 1'b0;
			pins_d.crossing_closed = 1'b1;
			pins_d.raise_drive     = 1'b0;
			pins_d.lower_drive     = !item.barrier_at_bottom;
			if (flash_toggle) begin
				if (!pins_q.warning_flash) begin
					pins_d.warning_flash = 1'b1;
					pins_d.gong_on       = item.gong_allowed;
				end else begin
					pins_d.warning_flash = 1'b0;
					pins_d.gong_on       = 1'b0;
				end
			end
		end
		if (go_amber) begin
			pins_d.lamp_red   = 1'b0;
			pins_d.lamp_amber = 1'b1;
			pins_d.lamp_green = 1'b0;
		end
		if (!cnt_nz) begin
			if (clr_done) begin
				pins_d.lamp_red   = 1'b0;
				pins_d.lamp_amber = 1'b0;
				pins_d.lamp_green = 1'b1;
			end
			if (enter_ra) begin
				pins_d.lamp_red        = 1'b1;
				pins_d.lamp_amber      = 1'b1;
				pins_d.lamp_green      = 1'b0;
				pins_d.warning_flash   = 1'b0;
				pins_d.crossing_closed = 1'b0;
			end
			pins_d.lower_drive = 1'b0;
			pins_d.raise_drive = !item.barrier_at_top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= PH_GREEN;
			amber_q <= '0;
			clear_q <= '0;
			flash_q <= '0;
			armed_q <= 1'b0;
			last_q  <= '0;
			pins_q  <= PINS_RST;
		end else if (step) begin
			count_q <= count_d;
			phase_q <= phase_d;
			amber_q <= amber_d;
			clear_q <= clear_d;
			flash_q <= flash_d;
			armed_q <= armed_q | cnt_nz;
			last_q  <= levels;
			pins_q  <= pins_d;
		end
	end

	assign pins = pins_q;

	function automatic logic [2:0] phase_lamps(phase_t ph);
		logic [2:0] l;
		case (ph)
			PH_GREEN:    l = 3'b100;
			PH_AMBER:    l = 3'b010;
			PH_RED:      l = 3'b001;
			PH_REDAMBER: l = 3'b011;
			default:     l = 3'b000;
		endcase
		return l;
	endfunction

	`LCC_ASSERT_ALWAYS(a_lamps_phase, {pins_q.lamp_green, pins_q.lamp_amber, pins_q.lamp_red} == phase_lamps(phase_q), "lamps disagree with phase")
	`LCC_ASSERT_ALWAYS(a_closed_red, pins_q.crossing_closed == (phase_q == PH_RED), "crossing_closed outside red")
	`LCC_ASSERT_ALWAYS(a_drives_excl, !(pins_q.lower_drive && pins_q.raise_drive), "both barrier drives on")
	`LCC_ASSERT_NEXT(a_count_up, step && rising == 2'b01 && count_q < CNT_MAX, count_q == CW'($past(count_q) + 1'b1), "entry edge not counted")

endmodule

`default_nettype wire

>>> design/level_crossing_controller_unit.sv
// Top level of the level crossing controller: stream ports, config registers, core.
//
//  channel   | direction | payload (lsb first)
//  ----------+-----------+-----------------------------------------------------
//  s_*       | in        | tick request: sensors, limit switches, gong switch
//  m_*       | out       | output latch: lamps, drives, flash, gong, closed
//  cfg_*     | in        | register write: flash, amber, clearance periods
//
// One request per clock while the m side keeps up: a request waits in the input
// register, the core then updates its state and output latch from it, and the
// latch is the result register seen on m_tdata.
// Reset (arst_n, async) clears all control state and loads register defaults.
// A stalled m side holds the latch; the input register still takes one request.
`default_nettype none

module level_crossing_controller_unit
	import lcc_pkg::*;
#(
	parameter int unsigned AXLE_COUNT_MAX = AXLE_COUNT_MAX_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	// entry_sensor, exit_sensor, barrier_at_top, barrier_at_bottom, gong_allowed, 3'b0
	input  wire  [7:0]            s_tdata,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// lamp_red, lamp_amber, lamp_green, lower_drive, raise_drive,
	// warning_flash, gong_on, crossing_closed
	output logic [7:0]            m_tdata,
	input  wire                   cfg_wr_en,
	input  wire  [CFG_INDEX_W-1:0] cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  out_valid_q;
	logic  step;
	pins_t pins;

	// config registers; index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flash_period    <= FLASH_PERIOD_RST;
			cfg_q.amber_ticks     <= AMBER_TICKS_RST;
			cfg_q.clearance_ticks <= CLEARANCE_TICKS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FLASH_PERIOD:    cfg_q.flash_period    <= cfg_data[5:0];
				REG_AMBER_TICKS:     cfg_q.amber_ticks     <= cfg_data[7:0];
				REG_CLEARANCE_TICKS: cfg_q.clearance_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// core fires when a request waits and the result slot is free or draining
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata[4:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	lcc_core #(
		.AXLE_COUNT_MAX(AXLE_COUNT_MAX)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (item_s1),
		.cfg   (cfg_q),
		.pins  (pins)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pins;

endmodule

`default_nettype wire

>>> test/level_crossing_controller_unit_tb.sv
// Stream-level testbench of the level crossing controller with its own tick-by-tick predictor.
`timescale 1ns / 100ps

module level_crossing_controller_unit_tb;
	import lcc_pkg::*;

	// index 3 decodes to no register and must leave the block untouched
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	// cycles with no request moving on either side before the run is declared hung
	localparam int STALL_LIMIT = 3000;
	// input register plus output latch, with some margin
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		item_t tick;
		bit    typed;
		pins_t want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// entry_sensor, exit_sensor, barrier_at_top, barrier_at_bottom, gong_allowed, 3'b0
	logic [7:0]             s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// lamp_red, lamp_amber, lamp_green, lower_drive, raise_drive,
	// warning_flash, gong_on, crossing_closed
	logic [7:0]             m_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor copy of the registers
	logic [5:0] cfg_flash = FLASH_PERIOD_RST;
	logic [7:0] cfg_amber = AMBER_TICKS_RST;
	logic [7:0] cfg_clear = CLEARANCE_TICKS_RST;

	// predictor copy of the controller state
	logic [7:0] axle_cnt = '0;
	phase_t     cur_phase = PH_GREEN;
	logic [7:0] amber_tmr = '0;
	logic [7:0] clear_tmr = '0;
	logic [5:0] flash_tmr = '0;
	bit         armed = 1'b0;
	logic [1:0] prev_levels = '0;
	pins_t      latch = PINS_RST;

	pins_t expected_pins_q[$];
	row_t  directed_rows[$];
	int    mismatch_count = 0;
	int    ticks_sent = 0;
	int    idle_cycles = 0;
	bit    steady = 1'b0;	// no idling on either side while set
	pins_t mon_want;
	pins_t mon_got;

	string pin_label [0:7] = '{"lamp_red", "lamp_amber", "lamp_green", "lower_drive",
		"raise_drive", "warning_flash", "gong_on", "crossing_closed"};

	level_crossing_controller_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One control tick of the controller: counts axle edges, steps the phase
	// machine and returns the output latch as it stands after the tick.
	function automatic pins_t advance_crossing(input item_t t);
		logic [1:0] levels;
		logic [1:0] rising;
		levels = {t.exit_sensor, t.entry_sensor};
		rising = levels & ~prev_levels;
		prev_levels = levels;
		// entry edge is counted before the exit edge of the same tick
		if (rising[0] && axle_cnt < AXLE_COUNT_MAX_DEF)
			axle_cnt = axle_cnt + 1'b1;
		if (rising[1] && axle_cnt != 0)
			axle_cnt = axle_cnt - 1'b1;

		if (axle_cnt != 0) begin
			armed = 1'b1;
			if (cur_phase == PH_RED || (cur_phase == PH_AMBER && amber_tmr >= cfg_amber)) begin
				// red: barrier down, warning lamp and gong toggle every flash period
				latch.lamp_red = 1'b1;
				latch.lamp_amber = 1'b0;
				latch.lamp_green = 1'b0;
				latch.crossing_closed = 1'b1;
				latch.raise_drive = 1'b0;
				latch.lower_drive = !t.barrier_at_bottom;
				flash_tmr = flash_tmr + 1'b1;
				if (flash_tmr >= cfg_flash) begin
					if (!latch.warning_flash) begin
						latch.warning_flash = 1'b1;
						latch.gong_on = t.gong_allowed;
					end else begin
						latch.warning_flash = 1'b0;
						latch.gong_on = 1'b0;
					end
					flash_tmr = '0;
				end
				cur_phase = PH_RED;
			end else if (cur_phase != PH_AMBER) begin
				// from green or red-amber: amber restarts at one
				latch.lamp_red = 1'b0;
				latch.lamp_amber = 1'b1;
				latch.lamp_green = 1'b0;
				amber_tmr = 8'd1;
				cur_phase = PH_AMBER;
			end else begin
				amber_tmr = amber_tmr + 1'b1;
			end
		end else begin
			// an empty track during amber holds the phase and lamps; the barrier drives still follow
			if (armed) begin
				if (cur_phase == PH_REDAMBER && clear_tmr >= cfg_clear) begin
					latch.lamp_red = 1'b0;
					latch.lamp_amber = 1'b0;
					latch.lamp_green = 1'b1;
					cur_phase = PH_GREEN;
					clear_tmr = '0;
					amber_tmr = '0;
				end else if (cur_phase == PH_RED) begin
					// gong_on is left as it was
					latch.lamp_red = 1'b1;
					latch.lamp_amber = 1'b1;
					latch.lamp_green = 1'b0;
					latch.warning_flash = 1'b0;
					latch.crossing_closed = 1'b0;
					clear_tmr = 8'd1;
					cur_phase = PH_REDAMBER;
				end else if (cur_phase == PH_REDAMBER) begin
					clear_tmr = clear_tmr + 1'b1;
				end
			end
			latch.lower_drive = 1'b0;
			latch.raise_drive = !t.barrier_at_top;
		end
		return latch;
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Result side: every accepted latch is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pins_q.size() == 0) begin
				flag_error($sformatf("result %b with no request pending", m_tdata));
			end else begin
				mon_want = expected_pins_q.pop_front();
				mon_got = pins_t'(m_tdata);
				for (int b = 0; b < 8; b++)
					if (mon_got[b] !== mon_want[b])
						flag_error($sformatf("%s got %b want %b", pin_label[b],
							mon_got[b], mon_want[b]));
			end
		end
	end

	// Result side backpressure, changed at the falling edge.
	initial begin
		forever begin
			@(negedge clk);
			m_tready <= steady || ($urandom_range(0, 99) >= 13);
		end
	end

	// Hang detector: nothing accepted on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("level_crossing_controller_unit test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Tasks below all start and end at a falling edge.

	// Offers one tick request, with random gaps ahead of it, and records the
	// expected latch once the request is taken.
	task automatic drive_tick(input item_t t, input bit typed, input pins_t want);
		pins_t pred;
		while (!steady && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, t};
		do @(posedge clk); while (!s_tready);
		pred = advance_crossing(t);
		expected_pins_q.push_back(typed ? want : pred);
		ticks_sent++;
		@(negedge clk);
	endtask

	// sensor levels as given, limit switches and gong switch at random
	task automatic send(input bit entry, input bit exit_lvl);
		item_t t;
		t.entry_sensor = entry;
		t.exit_sensor = exit_lvl;
		t.barrier_at_top = 1'($urandom_range(0, 1));
		t.barrier_at_bottom = 1'($urandom_range(0, 1));
		t.gong_allowed = 1'($urandom_range(0, 1));
		drive_tick(t, 1'b0, PINS_RST);
	endtask

	task automatic drain_results(input int extra);
		s_tvalid <= 1'b0;
		while (expected_pins_q.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_FLASH_PERIOD:    cfg_flash = val[5:0];
			REG_AMBER_TICKS:     cfg_amber = val;
			REG_CLEARANCE_TICKS: cfg_clear = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Block must be idle here; upper data bits of the flash period are don't-care.
	task automatic load_config(input logic [5:0] fp, input logic [7:0] am,
		input logic [7:0] cl);
		drain_results(SETTLE_CYCLES);
		write_reg(REG_SPARE, 8'($urandom));
		write_reg(REG_FLASH_PERIOD, {2'($urandom), fp});
		write_reg(REG_AMBER_TICKS, am);
		write_reg(REG_CLEARANCE_TICKS, cl);
	endtask

	// A train: axles roll in, dwell, roll out, then the track stays clear.
	// Exit count may be one less or up to two more than the entry count, and an entry may coincide with an exit.
	task automatic run_train();
		int n_in;
		int n_out;
		n_in = $urandom_range(1, 6);
		n_out = n_in + $urandom_range(0, 3) - 1;
		for (int i = 0; i < n_in; i++) begin
			repeat ($urandom_range(1, 3)) send(1'b1, 1'b0);
			repeat ($urandom_range(1, 3)) send(1'b0, 1'b0);
		end
		repeat ($urandom_range(0, int'(cfg_amber) + 2 * int'(cfg_flash) + 4))
			send(1'b0, 1'b0);
		for (int i = 0; i < n_out; i++) begin
			repeat ($urandom_range(1, 3)) send($urandom_range(0, 9) == 0, 1'b1);
			repeat ($urandom_range(1, 3)) send(1'b0, 1'b0);
		end
		repeat ($urandom_range(0, int'(cfg_clear) + 3)) send(1'b0, 1'b0);
	endtask

	// Settings first, then trains mixed with bursts of arbitrary ticks.
	// hold_mid stops the sender halfway until every result is back.
	task automatic run_phase(input logic [5:0] fp, input logic [7:0] am,
		input logic [7:0] cl, input int quota, input bit hold_mid);
		int start;
		load_config(fp, am, cl);
		start = ticks_sent;
		while (ticks_sent - start < quota) begin
			if (hold_mid && ticks_sent - start >= quota / 2) begin
				drain_results(0);
				hold_mid = 1'b0;
			end
			if ($urandom_range(0, 99) < 15)
				repeat ($urandom_range(1, 6)) drive_tick(item_t'(5'($urandom)), 1'b0, PINS_RST);
			else
				run_train();
		end
	endtask

	function automatic row_t tick_row(input bit e, input bit x, input bit top, input bit bot,
		input bit gong, input bit typed, input logic [7:0] want);
		row_t r;
		r.tick.entry_sensor = e;
		r.tick.exit_sensor = x;
		r.tick.barrier_at_top = top;
		r.tick.barrier_at_bottom = bot;
		r.tick.gong_allowed = gong;
		r.typed = typed;
		r.want = pins_t'(want);
		return r;
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk: flash period zero (toggle every red tick), one amber tick,
		// one clearance tick, so every phase is reached in a few requests.
		//                            entry exit top bot gong typed latch
		directed_rows.push_back(tick_row(0, 0, 1, 0, 0, 1, 8'h04));	// idle, barrier up
		directed_rows.push_back(tick_row(0, 0, 0, 0, 0, 1, 8'h14));	// raise until top
		directed_rows.push_back(tick_row(0, 1, 0, 0, 0, 1, 8'h14));	// exit at zero ignored
		directed_rows.push_back(tick_row(1, 0, 0, 0, 1, 1, 8'h12));	// first axle: amber
		directed_rows.push_back(tick_row(0, 1, 0, 0, 1, 0, 8'h00));	// clears during amber
		directed_rows.push_back(tick_row(0, 0, 1, 0, 1, 0, 8'h00));	// amber held
		directed_rows.push_back(tick_row(1, 0, 0, 0, 1, 0, 8'h00));	// next axle: red
		directed_rows.push_back(tick_row(1, 0, 0, 1, 1, 0, 8'h00));	// barrier down
		directed_rows.push_back(tick_row(0, 0, 0, 1, 0, 0, 8'h00));	// flash, gong off
		directed_rows.push_back(tick_row(1, 1, 0, 1, 1, 0, 8'h00));	// both edges at once
		directed_rows.push_back(tick_row(0, 0, 0, 1, 1, 0, 8'h00));
		directed_rows.push_back(tick_row(0, 1, 0, 1, 1, 0, 8'h00));	// red-amber, gong held
		directed_rows.push_back(tick_row(1, 0, 0, 0, 0, 0, 8'h00));	// axle in red-amber
		directed_rows.push_back(tick_row(0, 0, 0, 0, 0, 0, 8'h00));	// straight to red
		directed_rows.push_back(tick_row(0, 1, 0, 1, 0, 0, 8'h00));	// clear again
		directed_rows.push_back(tick_row(0, 1, 1, 1, 0, 1, 8'h04));	// back to green
		directed_rows.push_back(tick_row(0, 0, 1, 0, 0, 1, 8'h04));
		load_config(6'd0, 8'd1, 8'd1);
		foreach (directed_rows[i])
			drive_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);

		// default settings with both sides never idling
		steady = 1'b1;
		run_phase(FLASH_PERIOD_RST, AMBER_TICKS_RST, CLEARANCE_TICKS_RST, 40, 1'b0);
		steady = 1'b0;
		run_phase(6'd63, 8'd255, 8'd255, 50, 1'b0);	// top of every range
		run_phase(6'd1, 8'd1, 8'd1, 50, 1'b1);		// bottom of range, sender held midway
		run_phase(6'd0, 8'd0, 8'd0, 50, 1'b0);		// below range
		repeat (4)
			run_phase(6'($urandom_range(0, 9)), 8'($urandom_range(0, 14)),
				8'($urandom_range(0, 14)), 20, 1'b0);

		// Flood: the axle count saturates at its maximum, then drains to zero.
		load_config(6'd4, 8'd3, 8'd3);
		repeat (AXLE_COUNT_MAX_DEF + 5) begin
			send(1'b1, 1'b0);
			send(1'b0, 1'b0);
		end
		repeat (AXLE_COUNT_MAX_DEF + 5) begin
			send(1'b0, 1'b1);
			send(1'b0, 1'b0);
		end
		repeat (8) send(1'b0, 1'b0);

		drain_results(SETTLE_CYCLES);
		if (mismatch_count == 0)
			$display("level_crossing_controller_unit test passed");
		else
			$display("level_crossing_controller_unit test failed");
		$finish;
	end

endmodule
